FILE: hdl/spt_pkg.sv
// shared types and constants for the sparse polynomial term table
`timescale 1ns / 1ps

package spt_pkg;

   localparam int unsigned MAX_TERMS = 16;
   localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int unsigned CNT_W     = 5;
   localparam int unsigned COEFF_W   = 32;
   localparam int unsigned EXP_W     = 6;
   localparam int unsigned ENTRY_W   = COEFF_W + EXP_W;

   typedef enum logic [2:0] {
      CMD_APPEND = 3'd0,
      CMD_SET    = 3'd1,
      CMD_GET    = 3'd2,
      CMD_EVAL   = 3'd3,
      CMD_CLEAR  = 3'd4
   } spt_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_POW,
      ST_TERM,
      ST_SUM,
      ST_DONE
   } spt_state_type;

   typedef struct packed {
      logic [2:0]                cmd;
      logic signed [COEFF_W-1:0] coeff_in;
      logic [EXP_W-1:0]          exponent;
      logic signed [COEFF_W-1:0] point;
   } spt_req_type;

   typedef struct packed {
      logic signed [COEFF_W-1:0] value;
      logic [EXP_W-1:0]          degree;
      logic [CNT_W-1:0]          term_count;
      logic                      status;
   } spt_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic clear_tbl;
      logic append;
      logic write_hit;
      logic rd_first;
      logic rd_next;
      logic load_term;
      logic pow_mul;
      logic pow_sq;
      logic term_mul;
      logic sum_add;
      logic take_value;
      logic status_full;
      logic load_out;
   } spt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic full;
      logic match;
      logic last;
      logic e_zero;
      logic e_bit0;
   } spt_stat_type;

endpackage

FILE: hdl/sparse_polynomial_term_table.sv
// Sparse polynomial term table: top level.
// One transaction at a time; the next is accepted the cycle after the result register loads.
// Append and clear pass through decode to the result register; get and set walk
// the stored terms from the first until a match or the end of the table.
// Evaluate runs square and multiply for each stored term and sums the terms.
// Synchronous active-high reset empties the table; stored entries are not cleared.
`timescale 1ns / 1ps

// evaluate runs square and multiply on the single shared 32x32 multiplier; a result that
// is not taken holds the next transaction in its done state
module sparse_polynomial_term_table
   import spt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  spt_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spt_rsp_type rsp_payload
);

   spt_cmd_type  ctl;
   spt_stat_type stat;

   spt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   spt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hdl/spt_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module spt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/spt_dp.sv
// datapath: term store, shared multiplier, counters and result register
`timescale 1ns / 1ps

module spt_dp
   import spt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  spt_req_type  req_payload,
   input  spt_cmd_type  ctl,
   output spt_stat_type stat,
   output spt_rsp_type  rsp_payload
);

   logic [COEFF_W-1:0] coeff_ff, coeff_in;
   logic [EXP_W-1:0]   exp_ff, exp_in;
   logic [COEFF_W-1:0] point_ff, point_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [EXP_W-1:0]   degree_ff, degree_in;
   logic               status_ff, status_in;
   logic [COEFF_W-1:0] value_ff, value_in;
   logic [COEFF_W-1:0] acc_ff, acc_in;
   logic [COEFF_W-1:0] base_ff, base_in;
   logic [EXP_W-1:0]   pexp_ff, pexp_in;
   logic [COEFF_W-1:0] tcoeff_ff, tcoeff_in;
   spt_rsp_type        out_ff, out_in;

   logic [IDX_W-1:0]   idx_next;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [COEFF_W-1:0] rd_coeff;
   logic [EXP_W-1:0]   rd_exp;
   logic [COEFF_W-1:0] mul_a, mul_b, mul_p;

   assign idx_next = IDX_W'(idx_ff + 1'b1);
   assign rd_coeff = rd_data[ENTRY_W-1:EXP_W];
   assign rd_exp   = rd_data[EXP_W-1:0];

   // term store: coefficient and exponent side by side
   assign wr_en   = ctl.append | ctl.write_hit;
   assign wr_addr = ctl.write_hit ? idx_ff : count_ff[IDX_W-1:0];
   assign wr_data = {coeff_ff, exp_ff};
   assign rd_en   = ctl.rd_first | ctl.rd_next;
   assign rd_addr = ctl.rd_first ? '0 : idx_next;

   spt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TERMS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one shared multiplier, low word only
   always_comb begin
      mul_a = acc_ff;
      mul_b = base_ff;
      if (ctl.pow_sq) begin
         mul_a = base_ff;
      end else if (ctl.term_mul) begin
         mul_b = tcoeff_ff;
      end
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      coeff_in  = coeff_ff;
      exp_in    = exp_ff;
      point_in  = point_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      degree_in = degree_ff;
      status_in = status_ff;
      value_in  = value_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      pexp_in   = pexp_ff;
      tcoeff_in = tcoeff_ff;
      out_in    = out_ff;

      if (ctl.capture) begin
         coeff_in  = req_payload.coeff_in;
         exp_in    = req_payload.exponent;
         point_in  = req_payload.point;
         value_in  = '0;
         status_in = 1'b0;
      end
      if (ctl.clear_tbl) begin
         count_in  = '0;
         degree_in = '0;
      end
      if (ctl.append) begin
         count_in = CNT_W'(count_ff + 1'b1);
         if (exp_ff > degree_ff) begin
            degree_in = exp_ff;
         end
      end
      if (ctl.status_full) begin
         status_in = 1'b1;
      end
      if (ctl.rd_first) begin
         idx_in = '0;
      end else if (ctl.rd_next) begin
         idx_in = idx_next;
      end
      if (ctl.load_term) begin
         acc_in    = COEFF_W'(1);
         base_in   = point_ff;
         pexp_in   = rd_exp;
         tcoeff_in = rd_coeff;
      end
      // square and multiply, low exponent bit first
      if (ctl.pow_mul) begin
         acc_in     = mul_p;
         pexp_in[0] = 1'b0;
      end
      if (ctl.pow_sq) begin
         base_in = mul_p;
         pexp_in = pexp_ff >> 1;
      end
      if (ctl.term_mul) begin
         acc_in = mul_p;
      end
      if (ctl.sum_add) begin
         value_in = value_ff + acc_ff;
      end
      if (ctl.take_value) begin
         value_in = rd_coeff;
      end
      if (ctl.load_out) begin
         out_in.value      = value_ff;
         out_in.degree     = degree_ff;
         out_in.term_count = count_ff;
         out_in.status     = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         degree_ff <= '0;
      end else begin
         count_ff  <= count_in;
         degree_ff <= degree_in;
      end
   end

   always_ff @(posedge clock) begin
      coeff_ff  <= coeff_in;
      exp_ff    <= exp_in;
      point_ff  <= point_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      pexp_ff   <= pexp_in;
      tcoeff_ff <= tcoeff_in;
      out_ff    <= out_in;
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.full       = (count_ff == CNT_W'(MAX_TERMS));
   assign stat.match      = (rd_exp == exp_ff);
   assign stat.last       = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign stat.e_zero     = (pexp_ff == '0);
   assign stat.e_bit0     = pexp_ff[0];

   assign rsp_payload = out_ff;

endmodule

FILE: hdl/spt_ctrl.sv
// controller: command sequencing and result handshake
`timescale 1ns / 1ps

module spt_ctrl
   import spt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [2:0]   req_cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  spt_stat_type stat,
   output spt_cmd_type  ctl
);

   spt_state_type state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ctl       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               op_in       = req_cmd;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            unique case (op_ff)
               CMD_APPEND: begin
                  ctl.append      = ~stat.full;
                  ctl.status_full = stat.full;
               end
               CMD_SET: begin
                  if (stat.count_zero) begin
                     ctl.append = 1'b1;
                  end else begin
                     ctl.rd_first = 1'b1;
                     state_in     = ST_FETCH;
                  end
               end
               CMD_GET, CMD_EVAL: begin
                  if (!stat.count_zero) begin
                     ctl.rd_first = 1'b1;
                     state_in     = ST_FETCH;
                  end
               end
               CMD_CLEAR: begin
                  ctl.clear_tbl = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_FETCH: begin
            // read data for the current entry is valid here
            state_in = ST_DONE;
            unique case (op_ff)
               CMD_EVAL: begin
                  ctl.load_term = 1'b1;
                  state_in      = ST_POW;
               end
               CMD_SET: begin
                  if (stat.match) begin
                     ctl.write_hit = 1'b1;
                  end else if (stat.last) begin
                     ctl.append      = ~stat.full;
                     ctl.status_full = stat.full;
                  end else begin
                     ctl.rd_next = 1'b1;
                     state_in    = ST_FETCH;
                  end
               end
               CMD_GET: begin
                  if (stat.match) begin
                     ctl.take_value = 1'b1;
                  end else if (!stat.last) begin
                     ctl.rd_next = 1'b1;
                     state_in    = ST_FETCH;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_POW: begin
            if (stat.e_zero) begin
               state_in = ST_TERM;
            end else if (stat.e_bit0) begin
               ctl.pow_mul = 1'b1;
            end else begin
               ctl.pow_sq = 1'b1;
            end
         end
         ST_TERM: begin
            ctl.term_mul = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            ctl.sum_add = 1'b1;
            if (stat.last) begin
               state_in = ST_DONE;
            end else begin
               ctl.rd_next = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
